// File: design/mlu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlu_pkg
// shared types and constants of the mutex lock unit
// ----------------------------------------------------------------------------
package mlu_pkg;

  localparam int NumLocks  = 16;
  localparam int WaitDepth = 8;
  localparam int PidBits   = 8;
  localparam int IdW       = $clog2(NumLocks);
  localparam int WdW       = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
  localparam int CntW      = $clog2(WaitDepth + 1);
  localparam int SlotW     = $clog2(NumLocks + 1);

  typedef enum logic [1:0] {
    FN_CREATE  = 2'd0,
    FN_LOCK    = 2'd1,
    FN_UNLOCK  = 2'd2,
    FN_DESTROY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_REFUSED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] lock_id;
    logic [7:0] pid;
  } req_t;

endpackage

// File: design/mlu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlu_front
// input stage and two-entry request queue feeding the lock engine
// ----------------------------------------------------------------------------
module mlu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     func,
  input  logic [3:0]     lock_id,
  input  logic [7:0]     pid,
  output logic           req_valid,
  input  logic           req_take,
  output mlu_pkg::req_t  req
);

  mlu_pkg::req_t q [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= '{func: func, lock_id: lock_id, pid: pid};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: design/mlu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlu_back
// lock engine: slot table, waiter queues and result register
// ----------------------------------------------------------------------------
module mlu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_take,
  input  mlu_pkg::req_t  req,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     status,
  output logic [3:0]     new_id,
  output logic           woken_valid,
  output logic [7:0]     woken_pid
);

  localparam int MemW = mlu_pkg::IdW + mlu_pkg::WdW;

  logic [mlu_pkg::NumLocks-1:0]   slot_valid;
  logic [mlu_pkg::NumLocks-1:0]   slot_locked;
  logic [mlu_pkg::PidBits-1:0]    slot_owner [mlu_pkg::NumLocks];
  logic [mlu_pkg::WdW-1:0]        waiter_head [mlu_pkg::NumLocks];
  logic [mlu_pkg::CntW-1:0]       waiter_count [mlu_pkg::NumLocks];
  logic [mlu_pkg::PidBits-1:0]    waiter_store [2**MemW];
  logic [mlu_pkg::SlotW-1:0]      next_slot;

  // stage 1: registered request and memory read of the queue head
  logic                           s1_valid;
  mlu_pkg::req_t                  s1_req;
  logic [mlu_pkg::PidBits-1:0]    head_pid;

  logic                           out_valid;
  logic                           s1_go;
  logic [mlu_pkg::IdW-1:0]        s;
  logic [mlu_pkg::IdW-1:0]        in_s;
  logic [mlu_pkg::PidBits-1:0]    rpid;
  logic                           known;
  logic [mlu_pkg::WdW-1:0]        tail;
  logic [mlu_pkg::WdW-1:0]        head_inc;
  logic [mlu_pkg::CntW:0]         tail_sum;
  logic [mlu_pkg::WdW:0]          head_sum;
  logic [1:0]                     st_next;
  logic [3:0]                     nid_next;
  logic                           wv_next;
  logic [7:0]                     wp_next;
  logic                           wr_en;
  logic                           same_slot;

  assign empty    = !out_valid;
  assign s1_go    = s1_valid && (!out_valid || pop);
  // one item in flight keeps head reads coherent with writes
  assign req_take = req_valid && !s1_valid && (!out_valid || pop);
  assign s        = s1_req.lock_id[mlu_pkg::IdW-1:0];
  assign in_s     = req.lock_id[mlu_pkg::IdW-1:0];
  assign rpid     = s1_req.pid[mlu_pkg::PidBits-1:0];
  assign known    = slot_valid[s];
  assign tail_sum = {1'b0, waiter_head[s]} + waiter_count[s];
  assign tail     = tail_sum[mlu_pkg::WdW-1:0];
  assign head_sum = {1'b0, waiter_head[s]} + 1'b1;
  assign head_inc = head_sum[mlu_pkg::WdW-1:0];
  assign same_slot = 1'b0;

  always_comb begin
    st_next  = mlu_pkg::ST_OK;
    nid_next = '0;
    wv_next  = 1'b0;
    wp_next  = '0;
    wr_en    = 1'b0;
    case (mlu_pkg::func_t'(s1_req.func))
      mlu_pkg::FN_CREATE: begin
        if (next_slot < mlu_pkg::SlotW'(mlu_pkg::NumLocks)) begin
          nid_next = 4'(next_slot);
        end else begin
          st_next = mlu_pkg::ST_FULL;
        end
      end
      mlu_pkg::FN_LOCK: begin
        if (!known) begin
          st_next = mlu_pkg::ST_REFUSED;
        end else if (slot_locked[s] && slot_owner[s] != rpid) begin
          if (waiter_count[s] < mlu_pkg::CntW'(mlu_pkg::WaitDepth)) begin
            st_next = mlu_pkg::ST_BLOCKED;
            wr_en   = 1'b1;
          end else begin
            st_next = mlu_pkg::ST_FULL;
          end
        end
      end
      mlu_pkg::FN_UNLOCK: begin
        if (!known || !slot_locked[s] || slot_owner[s] != rpid) begin
          st_next = mlu_pkg::ST_REFUSED;
        end else if (waiter_count[s] != '0) begin
          wv_next = 1'b1;
          wp_next = 8'(head_pid);
        end
      end
      mlu_pkg::FN_DESTROY: begin
        if (!known) st_next = mlu_pkg::ST_REFUSED;
      end
      default: st_next = mlu_pkg::ST_REFUSED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_req   <= req;
      head_pid <= waiter_store[{in_s, waiter_head[in_s]}];
    end
    if (s1_go && wr_en) begin
      waiter_store[{s, tail}] <= rpid;
    end
    if (s1_go) begin
      status      <= st_next;
      new_id      <= nid_next;
      woken_valid <= wv_next;
      woken_pid   <= wp_next;
    end
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      slot_valid   <= '0;
      slot_locked  <= '0;
      next_slot    <= '0;
      for (int i = 0; i < mlu_pkg::NumLocks; i++) begin
        waiter_head[i]  <= '0;
        waiter_count[i] <= '0;
        slot_owner[i]   <= '0;
      end
    end else begin
      if (req_take)          s1_valid <= 1'b1;
      else if (s1_go)        s1_valid <= 1'b0;
      if (s1_go)             out_valid <= 1'b1;
      else if (pop)          out_valid <= 1'b0;
      if (s1_go && !same_slot) begin
        case (mlu_pkg::func_t'(s1_req.func))
          mlu_pkg::FN_CREATE: begin
            if (st_next == mlu_pkg::ST_OK) begin
              slot_valid[next_slot[mlu_pkg::IdW-1:0]]   <= 1'b1;
              slot_locked[next_slot[mlu_pkg::IdW-1:0]]  <= 1'b0;
              slot_owner[next_slot[mlu_pkg::IdW-1:0]]   <= '0;
              waiter_head[next_slot[mlu_pkg::IdW-1:0]]  <= '0;
              waiter_count[next_slot[mlu_pkg::IdW-1:0]] <= '0;
              next_slot <= next_slot + 1'b1;
            end
          end
          mlu_pkg::FN_LOCK: begin
            if (known && !slot_locked[s]) begin
              slot_locked[s] <= 1'b1;
              slot_owner[s]  <= rpid;
            end else if (wr_en) begin
              waiter_count[s] <= waiter_count[s] + 1'b1;
            end
          end
          mlu_pkg::FN_UNLOCK: begin
            if (st_next == mlu_pkg::ST_OK) begin
              if (wv_next) begin
                waiter_head[s]  <= head_inc;
                waiter_count[s] <= waiter_count[s] - 1'b1;
                slot_owner[s]   <= head_pid;
              end else begin
                slot_locked[s] <= 1'b0;
                slot_owner[s]  <= '0;
              end
            end
          end
          mlu_pkg::FN_DESTROY: begin
            if (known) begin
              slot_valid[s]   <= 1'b0;
              slot_locked[s]  <= 1'b0;
              slot_owner[s]   <= '0;
              waiter_head[s]  <= '0;
              waiter_count[s] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: design/mutex_lock_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_lock_unit
// lock slot table with per-lock fifo of waiting processes
// an accepted push passes through the request queue, the stage and the out reg to the output
// one transaction at a time: the next enters the stage only after the last has left it,
//   set by the single-item head read of the waiter memory ahead of the table update
// reset: synchronous rst clears slots, queue counts and all control state
// ----------------------------------------------------------------------------
module mutex_lock_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func,
  input  logic [3:0] lock_id,
  input  logic [7:0] pid,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status,
  output logic [3:0] new_id,
  output logic       woken_valid,
  output logic [7:0] woken_pid
);

  logic          req_valid;
  logic          req_take;
  mlu_pkg::req_t req;

  mlu_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .func(func), .lock_id(lock_id), .pid(pid),
    .req_valid(req_valid), .req_take(req_take), .req(req)
  );

  mlu_back u_back (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_take(req_take), .req(req),
    .empty(empty), .pop(pop), .status(status), .new_id(new_id),
    .woken_valid(woken_valid), .woken_pid(woken_pid)
  );

endmodule

// File: design/mlu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlu_checker
// port-level checks of the mutex lock unit
// ----------------------------------------------------------------------------
module mlu_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [1:0] status,
  input logic [3:0] new_id,
  input logic       woken_valid,
  input logic [7:0] woken_pid
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not empty after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(woken_pid))
    else $error("waiting result changed");
  a_woken_ok: assert property (@(posedge clk) disable iff (rst)
    !empty && woken_valid |-> status == mlu_pkg::ST_OK)
    else $error("handoff with bad status");
  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !woken_valid |-> woken_pid == 8'd0)
    else $error("woken pid without handoff");
  a_newid: assert property (@(posedge clk) disable iff (rst)
    !empty && status != mlu_pkg::ST_OK |-> new_id == 4'd0)
    else $error("new id on failure");

endmodule

bind mutex_lock_unit mlu_checker u_mlu_checker (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .status(status), .new_id(new_id), .woken_valid(woken_valid), .woken_pid(woken_pid)
);

// File: verif/mutex_lock_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_lock_unit_tb
// drives lock table operations through the push/full side and checks every
// result popped from the output side against a cycle-free model of the slot
// table, owners and per-lock waiter fifos; sender gaps and receiver stalls vary
// by phase
// ----------------------------------------------------------------------------
module mutex_lock_unit_tb;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] new_id;
    logic       woken_valid;
    logic [7:0] woken_pid;
  } lock_result_t;

  class lock_scoreboard;
    bit           valid_q[mlu_pkg::NumLocks];
    bit           locked_q[mlu_pkg::NumLocks];
    logic [7:0]   owner_q[mlu_pkg::NumLocks];
    logic [7:0]   waiters[mlu_pkg::NumLocks][mlu_pkg::WaitDepth];
    int           head_q[mlu_pkg::NumLocks];
    int           count_q[mlu_pkg::NumLocks];
    int           next_slot;
    lock_result_t pending[$];
    int           errors;

    function void clear();
      for (int i = 0; i < mlu_pkg::NumLocks; i++) begin
        valid_q[i] = 0;
        locked_q[i] = 0;
        owner_q[i] = '0;
        head_q[i] = 0;
        count_q[i] = 0;
      end
      next_slot = 0;
      errors = 0;
      pending.delete();
    endfunction

    function void note_request(mlu_pkg::func_t fn, logic [3:0] id, logic [7:0] p);
      lock_result_t r;
      int tail;
      r = '0;
      r.status = mlu_pkg::ST_OK;
      if (fn == mlu_pkg::FN_CREATE) begin
        if (next_slot < mlu_pkg::NumLocks) begin
          valid_q[next_slot] = 1;
          locked_q[next_slot] = 0;
          owner_q[next_slot] = '0;
          head_q[next_slot] = 0;
          count_q[next_slot] = 0;
          r.new_id = next_slot[3:0];
          next_slot++;
        end else begin
          r.status = mlu_pkg::ST_FULL;
        end
      end else if (!valid_q[id]) begin
        r.status = mlu_pkg::ST_REFUSED;
      end else if (fn == mlu_pkg::FN_LOCK) begin
        if (!locked_q[id]) begin
          locked_q[id] = 1;
          owner_q[id] = p;
        end else if (owner_q[id] == p) begin
          r.status = mlu_pkg::ST_OK;
        end else if (count_q[id] < mlu_pkg::WaitDepth) begin
          tail = (head_q[id] + count_q[id]) % mlu_pkg::WaitDepth;
          waiters[id][tail] = p;
          count_q[id]++;
          r.status = mlu_pkg::ST_BLOCKED;
        end else begin
          r.status = mlu_pkg::ST_FULL;
        end
      end else if (fn == mlu_pkg::FN_UNLOCK) begin
        if (!locked_q[id] || owner_q[id] != p) begin
          r.status = mlu_pkg::ST_REFUSED;
        end else if (count_q[id] > 0) begin
          owner_q[id] = waiters[id][head_q[id]];
          head_q[id] = (head_q[id] + 1) % mlu_pkg::WaitDepth;
          count_q[id]--;
          r.woken_valid = 1;
          r.woken_pid = owner_q[id];
        end else begin
          locked_q[id] = 0;
          owner_q[id] = '0;
        end
      end else begin
        valid_q[id] = 0;
        locked_q[id] = 0;
        owner_q[id] = '0;
        head_q[id] = 0;
        count_q[id] = 0;
      end
      pending = {pending, r};
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.new_id !== exp.new_id) begin
        $display("%0t: new_id exp %0d got %0d", $time, exp.new_id, got.new_id);
        errors++;
      end
      if (got.woken_valid !== exp.woken_valid) begin
        $display("%0t: woken_valid exp %0d got %0d", $time, exp.woken_valid,
                 got.woken_valid);
        errors++;
      end
      if (got.woken_pid !== exp.woken_pid) begin
        $display("%0t: woken_pid exp %0d got %0d", $time, exp.woken_pid, got.woken_pid);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] func;
  logic [3:0] lock_id;
  logic [7:0] pid;
  logic       empty;
  logic       pop;
  logic [1:0] status;
  logic [3:0] new_id;
  logic       woken_valid;
  logic [7:0] woken_pid;

  lock_scoreboard sb;
  int idle_pct;
  int stall_pct;

  mutex_lock_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .lock_id(lock_id), .pid(pid), .empty(empty), .pop(pop), .status(status),
    .new_id(new_id), .woken_valid(woken_valid), .woken_pid(woken_pid)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, check on accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) sb.check_result({status, new_id, woken_valid, woken_pid});
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(mlu_pkg::func_t fn, logic [3:0] id, logic [7:0] p);
    while ($urandom_range(99) < idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    func <= fn;
    lock_id <= id;
    pid <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(fn, id, p);
  endtask

  task automatic hold_until_drained();
    push <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // any slot id, a few owners and pids so locks contend
  task automatic random_op();
    mlu_pkg::func_t fn;
    logic [3:0] id;
    logic [7:0] p;
    int r;
    r = $urandom_range(99);
    if (r < 3) fn = mlu_pkg::FN_CREATE;
    else if (r < 55) fn = mlu_pkg::FN_LOCK;
    else if (r < 95) fn = mlu_pkg::FN_UNLOCK;
    else fn = mlu_pkg::FN_DESTROY;
    id = $urandom_range(15);
    r = $urandom_range(99);
    if (fn == mlu_pkg::FN_UNLOCK && r < 60 && sb.valid_q[id] && sb.locked_q[id])
      p = sb.owner_q[id];
    else if (r < 85) p = 8'($urandom_range(5)) | 8'hA0;
    else p = 8'($urandom_range(255));
    send(fn, id, p);
  endtask

  initial begin
    sb = new();
    sb.clear();
    idle_pct = 0;
    stall_pct = 0;
    rst = 1;
    push = 0;
    func = mlu_pkg::FN_CREATE;
    lock_id = '0;
    pid = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: unknown slots, create, reentry, queue, handoff, full, destroy
    send(mlu_pkg::FN_LOCK, 4'd0, 8'h00);
    send(mlu_pkg::FN_UNLOCK, 4'd15, 8'hFF);
    send(mlu_pkg::FN_DESTROY, 4'd3, 8'h55);
    send(mlu_pkg::FN_CREATE, 4'd9, 8'hFF);
    send(mlu_pkg::FN_CREATE, 4'd0, 8'h00);
    send(mlu_pkg::FN_LOCK, 4'd0, 8'hFF);
    send(mlu_pkg::FN_LOCK, 4'd0, 8'hFF);
    send(mlu_pkg::FN_UNLOCK, 4'd0, 8'h00);
    for (int i = 0; i < mlu_pkg::WaitDepth; i++) send(mlu_pkg::FN_LOCK, 4'd0, 8'(i + 1));
    send(mlu_pkg::FN_LOCK, 4'd0, 8'h01);
    send(mlu_pkg::FN_UNLOCK, 4'd0, 8'hFF);
    send(mlu_pkg::FN_UNLOCK, 4'd0, 8'h01);
    send(mlu_pkg::FN_DESTROY, 4'd0, 8'hAA);
    send(mlu_pkg::FN_LOCK, 4'd0, 8'h02);
    send(mlu_pkg::FN_UNLOCK, 4'd1, 8'h00);
    send(mlu_pkg::FN_UNLOCK, 4'd1, 8'h00);
    hold_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 24) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 24) : 0;
      for (int n = 0; n < 208; n++) random_op();
      if (ph == 1) hold_until_drained();
    end
    // exhausted create
    for (int i = 0; i < mlu_pkg::NumLocks + 2; i++)
      send(mlu_pkg::FN_CREATE, 4'($urandom_range(15)), 8'hFF);
    push <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
